// ===== hw/rtl/tga_rle_pkg.sv =====
// Shared types, sizes and helper functions for the TGA row run-length encoder.
// Used by tga_rle_lit_buf and tga_rle_row_encoder; depends on nothing else.
`timescale 1ns / 1ps

package tga_rle_pkg;

   localparam int PIX_W   = 24;
   localparam int MAX_PIX = 128;
   localparam int LANES   = 4;
   localparam int LANE_W  = $clog2(LANES);
   localparam int IDX_W   = $clog2(MAX_PIX);
   localparam int ROW_W   = IDX_W - LANE_W;
   localparam int ROWS    = 2 ** ROW_W;
   localparam int CNT_W   = $clog2(MAX_PIX + 1);
   localparam int HDR_W   = 8;
   localparam int PV_W    = 3;

   localparam int RSP_BITS    = HDR_W + PV_W + LANES * PIX_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD     = RSP_TDATA_W - RSP_BITS;

   localparam logic [HDR_W-1:0] RUN_FLAG = 8'h80;
   localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_PIX);
   localparam logic [CNT_W-1:0] RUN_MIN  = CNT_W'(2);

   typedef logic [PIX_W-1:0] pixel_type;
   typedef pixel_type [LANES-1:0] row_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      pixel_type        data;
   } lit_wr_type;

   // Packet header length field: pixel count minus one in the low seven bits.
   function automatic logic [HDR_W-1:0] len_hdr(input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] m;
      m = n - 1'b1;
      return {1'b0, m[HDR_W-2:0]};
   endfunction

endpackage

// ===== hw/rtl/tga_rle_lit_buf.sv =====
// Literal pixel buffer: four banks with one write and one read port each, one pixel written per cycle,
// one row of four pixels read per cycle with registered data. Uses tga_rle_pkg.
`timescale 1ns / 1ps

module tga_rle_lit_buf (
   input  logic                          clock,
   input  tga_rle_pkg::lit_wr_type       wr,
   input  logic [tga_rle_pkg::ROW_W-1:0] rd_row,
   output tga_rle_pkg::row_type          rd_data
);

   for (genvar lane = 0; lane < tga_rle_pkg::LANES; lane++) begin : g_bank
      tga_rle_pkg::pixel_type mem [tga_rle_pkg::ROWS];
      tga_rle_pkg::pixel_type rd_data_ff;

      always_ff @(posedge clock) begin
         if (wr.en && (wr.idx[tga_rle_pkg::LANE_W-1:0] == tga_rle_pkg::LANE_W'(lane))) begin
            mem[wr.idx[tga_rle_pkg::IDX_W-1:tga_rle_pkg::LANE_W]] <= wr.data;
         end
         rd_data_ff <= mem[rd_row];
      end

      assign rd_data[lane] = rd_data_ff;
   end

endmodule

// ===== hw/rtl/tga_rle_row_encoder.sv =====
// The encoder takes one BGR pixel per transaction and emits TGA run-length packets
// that never span a row, up to four pixels per result transaction. A pixel that
// neither starts nor ends a packet is taken in ST_IDLE. A run packet leaves from
// ST_RUN as one result; a raw packet of n pixels passes ST_PRIME to prime the read
// of the literal buffer, then ST_RAW sends ceil(n/4) results, one buffer row per
// cycle while the result register is free, as the buffer has a single read port.
// An item with row_end set also passes ST_LAST for the flush decision. No input is
// taken while packets are being sent; the result register lets the next item in
// while the final result waits. Depends on tga_rle_pkg and tga_rle_lit_buf.
`timescale 1ns / 1ps

module tga_rle_row_encoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [23:0]                         req_tdata,  // pixel_bgr
   input  logic                                req_tlast,  // row_end
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // packet_header, pixels_valid, color_a, color_b, color_c, color_d, zero fill
   output logic [tga_rle_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                                rsp_tuser,  // has_header
   output logic                                rsp_tlast   // last_result
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PRIME = 3'd1;
   localparam logic [2:0] ST_RAW   = 3'd2;
   localparam logic [2:0] ST_RUN   = 3'd3;
   localparam logic [2:0] ST_LAST  = 3'd4;

   localparam logic [tga_rle_pkg::CNT_W-1:0] CNT_ONE = tga_rle_pkg::CNT_W'(1);

   logic [2:0]                          state_ff, state_in;
   tga_rle_pkg::pixel_type              held_ff, held_in;
   logic                                held_valid_ff, held_valid_in;
   logic [tga_rle_pkg::CNT_W-1:0]       run_ff, run_in;
   logic [tga_rle_pkg::CNT_W-1:0]       count_ff, count_in;
   logic                                last_ff, last_in;
   logic                                phase_ff, phase_in;
   logic                                raw_pend_ff, raw_pend_in;
   logic                                run_pend_ff, run_pend_in;
   logic [tga_rle_pkg::HDR_W-1:0]       run_hdr_ff, run_hdr_in;
   tga_rle_pkg::pixel_type              run_pix_ff, run_pix_in;
   logic [tga_rle_pkg::ROW_W-1:0]       rd_row_ff, rd_row_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                out_hflag_ff, out_hflag_in;
   logic [tga_rle_pkg::HDR_W-1:0]       out_header_ff, out_header_in;
   logic [tga_rle_pkg::PV_W-1:0]        out_pv_ff, out_pv_in;
   tga_rle_pkg::row_type                out_color_ff, out_color_in;
   logic                                out_last_ff, out_last_in;

   tga_rle_pkg::lit_wr_type             wr;
   tga_rle_pkg::row_type                rd_data;

   logic                                out_free;
   logic                                same;
   logic                                need_last;
   logic [tga_rle_pkg::CNT_W-1:0]       run_inc;
   logic [tga_rle_pkg::CNT_W-1:0]       count_inc;
   logic [tga_rle_pkg::CNT_W-1:0]       remaining;
   logic                                tail;

   tga_rle_lit_buf u_lit_buf (
      .clock   (clock),
      .wr      (wr),
      .rd_row  (rd_row_in),
      .rd_data (rd_data)
   );

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign same      = (req_tdata == held_ff);
   assign need_last = last_ff && !phase_ff && held_valid_ff;
   assign run_inc   = run_ff + 1'b1;
   assign count_inc = count_ff + 1'b1;
   assign remaining = count_ff - tga_rle_pkg::CNT_W'({rd_row_ff, tga_rle_pkg::LANE_W'(0)});
   assign tail      = (remaining <= tga_rle_pkg::CNT_W'(tga_rle_pkg::LANES));

   always_comb begin
      state_in      = state_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      run_in        = run_ff;
      count_in      = count_ff;
      last_in       = last_ff;
      phase_in      = phase_ff;
      raw_pend_in   = raw_pend_ff;
      run_pend_in   = run_pend_ff;
      run_hdr_in    = run_hdr_ff;
      run_pix_in    = run_pix_ff;
      rd_row_in     = rd_row_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      out_hflag_in  = out_hflag_ff;
      out_header_in = out_header_ff;
      out_pv_in     = out_pv_ff;
      out_color_in  = out_color_ff;
      out_last_in   = out_last_ff;
      wr            = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               last_in     = req_tlast;
               phase_in    = 1'b0;
               raw_pend_in = 1'b0;
               run_pend_in = 1'b0;
               if (!held_valid_ff) begin
                  held_in       = req_tdata;
                  held_valid_in = 1'b1;
                  run_in        = '0;
               end else if (run_ff >= tga_rle_pkg::RUN_MIN) begin
                  if (same) begin
                     if (run_inc >= tga_rle_pkg::MAX_CNT) begin
                        run_pend_in   = 1'b1;
                        run_hdr_in    = tga_rle_pkg::RUN_FLAG | tga_rle_pkg::len_hdr(run_inc);
                        run_pix_in    = held_ff;
                        held_valid_in = 1'b0;
                        run_in        = '0;
                     end else begin
                        run_in = run_inc;
                     end
                  end else begin
                     run_pend_in = 1'b1;
                     run_hdr_in  = tga_rle_pkg::RUN_FLAG | tga_rle_pkg::len_hdr(run_ff);
                     run_pix_in  = held_ff;
                     held_in     = req_tdata;
                     run_in      = '0;
                  end
               end else if (same) begin
                  raw_pend_in = (count_ff != '0);
                  if (tga_rle_pkg::RUN_MIN >= tga_rle_pkg::MAX_CNT) begin
                     run_pend_in   = 1'b1;
                     run_hdr_in    = tga_rle_pkg::RUN_FLAG
                                   | tga_rle_pkg::len_hdr(tga_rle_pkg::RUN_MIN);
                     run_pix_in    = held_ff;
                     held_valid_in = 1'b0;
                     run_in        = '0;
                  end else begin
                     run_in = tga_rle_pkg::RUN_MIN;
                  end
               end else begin
                  wr.en       = 1'b1;
                  wr.idx      = count_ff[tga_rle_pkg::IDX_W-1:0];
                  wr.data     = held_ff;
                  count_in    = count_inc;
                  raw_pend_in = (count_inc >= tga_rle_pkg::MAX_CNT);
                  held_in     = req_tdata;
               end

               if (raw_pend_in) begin
                  state_in = ST_PRIME;
               end else if (run_pend_in) begin
                  state_in = ST_RUN;
               end else if (req_tlast) begin
                  state_in = ST_LAST;
               end
            end
         end

         ST_PRIME: begin
            rd_row_in = '0;
            state_in  = ST_RAW;
         end

         ST_RAW: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_hflag_in  = (rd_row_ff == '0);
               out_header_in = (rd_row_ff == '0) ? tga_rle_pkg::len_hdr(count_ff) : '0;
               out_pv_in     = tail ? remaining[tga_rle_pkg::PV_W-1:0]
                                    : tga_rle_pkg::PV_W'(tga_rle_pkg::LANES);
               for (int l = 0; l < tga_rle_pkg::LANES; l++) begin
                  out_color_in[l] = (tga_rle_pkg::CNT_W'(l) < remaining) ? rd_data[l] : '0;
               end
               out_last_in = tail && !run_pend_ff && !need_last;
               if (tail) begin
                  count_in    = '0;
                  raw_pend_in = 1'b0;
                  rd_row_in   = '0;
                  if (run_pend_ff) begin
                     state_in = ST_RUN;
                  end else if (need_last) begin
                     state_in = ST_LAST;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  rd_row_in = rd_row_ff + 1'b1;
               end
            end
         end

         ST_RUN: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               out_hflag_in    = 1'b1;
               out_header_in   = run_hdr_ff;
               out_pv_in       = tga_rle_pkg::PV_W'(1);
               out_color_in    = '0;
               out_color_in[0] = run_pix_ff;
               out_last_in     = !need_last;
               run_pend_in     = 1'b0;
               state_in        = need_last ? ST_LAST : ST_IDLE;
            end
         end

         ST_LAST: begin
            phase_in = 1'b1;
            state_in = ST_IDLE;
            if (held_valid_ff) begin
               if (run_ff < tga_rle_pkg::RUN_MIN) begin
                  wr.en       = 1'b1;
                  wr.idx      = count_ff[tga_rle_pkg::IDX_W-1:0];
                  wr.data     = held_ff;
                  count_in    = count_inc;
                  raw_pend_in = 1'b1;
                  state_in    = ST_PRIME;
               end else begin
                  run_pend_in = 1'b1;
                  run_hdr_in  = tga_rle_pkg::RUN_FLAG | tga_rle_pkg::len_hdr(run_ff);
                  run_pix_in  = held_ff;
                  state_in    = ST_RUN;
               end
            end
            held_in       = '0;
            held_valid_in = 1'b0;
            run_in        = '0;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         run_ff        <= '0;
         count_ff      <= '0;
         last_ff       <= 1'b0;
         phase_ff      <= 1'b0;
         raw_pend_ff   <= 1'b0;
         run_pend_ff   <= 1'b0;
         rd_row_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         run_ff        <= run_in;
         count_ff      <= count_in;
         last_ff       <= last_in;
         phase_ff      <= phase_in;
         raw_pend_ff   <= raw_pend_in;
         run_pend_ff   <= run_pend_in;
         rd_row_ff     <= rd_row_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      run_hdr_ff    <= run_hdr_in;
      run_pix_ff    <= run_pix_in;
      out_hflag_ff  <= out_hflag_in;
      out_header_ff <= out_header_in;
      out_pv_ff     <= out_pv_in;
      out_color_ff  <= out_color_in;
      out_last_ff   <= out_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{tga_rle_pkg::RSP_PAD{1'b0}}, out_color_ff, out_pv_ff, out_header_ff};
   assign rsp_tuser  = out_hflag_ff;
   assign rsp_tlast  = out_last_ff;

   // While idle, a run in progress and a missing lookahead pixel both imply an empty raw buffer.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) && ((run_ff >= tga_rle_pkg::RUN_MIN) || !held_valid_ff)
      |-> (count_ff == '0))
      else $error("raw pixels pending while idle in a run or without lookahead");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff <= tga_rle_pkg::MAX_CNT) && (run_ff != CNT_ONE)
      && (run_ff < tga_rle_pkg::MAX_CNT))
      else $error("packet length counters out of range");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!raw_pend_ff && !run_pend_ff))
      else $error("packet still pending while accepting input");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((out_pv_ff != '0) && (out_pv_ff <= tga_rle_pkg::PV_W'(tga_rle_pkg::LANES))))
      else $error("result pixel count out of range");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RAW) |-> (count_ff != '0))
      else $error("raw packet sent with no pixels");

endmodule
